// File: rtl/cam_pkg.sv
// ----------------------------------------------------------------------------
// Camellia cipher package
// Shared types, constants and decode functions for the Camellia block cipher.
// ----------------------------------------------------------------------------
package cam_pkg;

  localparam int KIDX_W = 6;

  localparam logic [KIDX_W-1:0] KW_BASE = 6'd0;
  localparam logic [KIDX_W-1:0] K_BASE  = 6'd4;
  localparam logic [KIDX_W-1:0] KE_BASE = 6'd28;

  localparam logic [2:0] CFG_KEY0 = 3'd0;
  localparam logic [2:0] CFG_KEY1 = 3'd1;
  localparam logic [2:0] CFG_KEY2 = 3'd2;
  localparam logic [2:0] CFG_KEY3 = 3'd3;
  localparam logic [2:0] CFG_KLEN = 3'd4;

  localparam logic [1:0] KLEN_128 = 2'd0;
  localparam logic [1:0] KLEN_192 = 2'd1;

  localparam logic [63:0] SIGMA [6] = '{
    64'hA09E667F3BCC908B, 64'hB67AE8584CAA73B2, 64'hC6EF372FE94F82BE,
    64'h54FF53A5F1D36F1C, 64'h10E527FADE682D1D, 64'hB05688C2B3E6C1FD
  };

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_KEYF = 5'b00010,
    ST_KEYW = 5'b00100,
    ST_RUN  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  typedef enum logic [2:0] {
    OP_XOR_HI,
    OP_XOR_LO,
    OP_F_EVEN,
    OP_F_ODD,
    OP_FL,
    OP_FLINV
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [KIDX_W-1:0] addr;
  } op_t;

  typedef enum logic [1:0] {
    SRC_KL,
    SRC_KR,
    SRC_KA,
    SRC_KB
  } key_src_t;

  typedef struct packed {
    logic [KIDX_W-1:0] idx;
    key_src_t          src;
    logic [6:0]        rot;
    logic              hi;
  } sched_t;

  function automatic logic [31:0] rotl32_one(logic [31:0] v);
    return {v[30:0], v[31]};
  endfunction

  function automatic logic [63:0] fl(logic [63:0] x, logic [63:0] k);
    logic [31:0] x1;
    logic [31:0] x2;
    x1 = x[63:32];
    x2 = x[31:0] ^ rotl32_one(x[63:32] & k[63:32]);
    x1 = x1 ^ (x2 | k[31:0]);
    return {x1, x2};
  endfunction

  function automatic logic [63:0] flinv(logic [63:0] y, logic [63:0] k);
    logic [31:0] y1;
    logic [31:0] y2;
    y1 = y[63:32] ^ (y[31:0] | k[31:0]);
    y2 = y[31:0] ^ rotl32_one(y1 & k[63:32]);
    return {y1, y2};
  endfunction

  // Operation p of one block: two whitening steps, then groups of eight
  // (six rounds followed by an FL pair, or by the final whitening).
  function automatic op_t cam_op(logic big, logic dec, logic [KIDX_W-1:0] p);
    op_t         o;
    logic [5:0]  q;
    logic [5:0]  i;
    logic [5:0]  ki;
    logic [5:0]  e0;
    logic [5:0]  e;
    logic [5:0]  rounds;
    logic [2:0]  lay;
    logic [2:0]  j;
    logic [2:0]  layers;
    logic [1:0]  w;
    rounds = big ? 6'd24 : 6'd18;
    layers = big ? 3'd3 : 3'd2;
    q      = p - 6'd2;
    lay    = q[5:3];
    j      = q[2:0];
    i      = {1'b0, lay, 2'b00} + {2'b00, lay, 1'b0} + {3'b000, j};
    o.kind = OP_XOR_HI;
    o.addr = KW_BASE;
    if (p < 6'd2) begin
      w      = p[1:0];
      o.kind = p[0] ? OP_XOR_LO : OP_XOR_HI;
      o.addr = KW_BASE + {4'b0000, dec ? (w ^ 2'd2) : w};
    end else if (j < 3'd6) begin
      ki     = dec ? (rounds - 6'd1 - i) : i;
      o.kind = j[0] ? OP_F_ODD : OP_F_EVEN;
      o.addr = K_BASE + ki;
    end else if (lay == layers) begin
      w      = (j == 3'd6) ? 2'd2 : 2'd3;
      o.kind = (j == 3'd6) ? OP_XOR_LO : OP_XOR_HI;
      o.addr = KW_BASE + {4'b0000, dec ? (w ^ 2'd2) : w};
    end else begin
      e0     = dec ? {2'b00, layers - 3'd1 - lay, 1'b1} : {2'b00, lay, 1'b0};
      e      = (j == 3'd6) ? e0 : (dec ? e0 - 6'd1 : e0 + 6'd1);
      o.kind = (j == 3'd6) ? OP_FL : OP_FLINV;
      o.addr = KE_BASE + e;
    end
    return o;
  endfunction

  // Subkey store write s: pairs of entries, high half first.
  function automatic sched_t sched_entry(logic big, logic [KIDX_W-1:0] s);
    sched_t            e;
    logic [4:0]        q;
    logic [KIDX_W-1:0] base;
    q     = s[5:1];
    base  = 6'd0;
    e.src = SRC_KL;
    e.rot = 7'd0;
    if (!big) begin
      case (q)
        5'd0:  begin base = 6'd0;  e.src = SRC_KL; e.rot = 7'd0;   end
        5'd1:  begin base = 6'd4;  e.src = SRC_KA; e.rot = 7'd0;   end
        5'd2:  begin base = 6'd6;  e.src = SRC_KL; e.rot = 7'd15;  end
        5'd3:  begin base = 6'd8;  e.src = SRC_KA; e.rot = 7'd15;  end
        5'd4:  begin base = 6'd28; e.src = SRC_KA; e.rot = 7'd30;  end
        5'd5:  begin base = 6'd10; e.src = SRC_KL; e.rot = 7'd45;  end
        5'd6:  begin base = 6'd12; e.src = SRC_KA; e.rot = 7'd45;  end
        5'd7:  begin base = 6'd14; e.src = SRC_KA; e.rot = 7'd60;  end
        5'd8:  begin base = 6'd30; e.src = SRC_KL; e.rot = 7'd77;  end
        5'd9:  begin base = 6'd16; e.src = SRC_KL; e.rot = 7'd94;  end
        5'd10: begin base = 6'd18; e.src = SRC_KA; e.rot = 7'd94;  end
        5'd11: begin base = 6'd20; e.src = SRC_KL; e.rot = 7'd111; end
        5'd12: begin base = 6'd2;  e.src = SRC_KA; e.rot = 7'd111; end
        default: begin base = 6'd0; end
      endcase
      // k10 comes from the low half of KL rotated by 60, not from KA.
      if (q == 5'd6 && s[0]) begin
        e.src = SRC_KL;
        e.rot = 7'd60;
      end
    end else begin
      case (q)
        5'd0:  begin base = 6'd0;  e.src = SRC_KL; e.rot = 7'd0;   end
        5'd1:  begin base = 6'd4;  e.src = SRC_KB; e.rot = 7'd0;   end
        5'd2:  begin base = 6'd6;  e.src = SRC_KR; e.rot = 7'd15;  end
        5'd3:  begin base = 6'd8;  e.src = SRC_KA; e.rot = 7'd15;  end
        5'd4:  begin base = 6'd28; e.src = SRC_KR; e.rot = 7'd30;  end
        5'd5:  begin base = 6'd10; e.src = SRC_KB; e.rot = 7'd30;  end
        5'd6:  begin base = 6'd12; e.src = SRC_KL; e.rot = 7'd45;  end
        5'd7:  begin base = 6'd14; e.src = SRC_KA; e.rot = 7'd45;  end
        5'd8:  begin base = 6'd30; e.src = SRC_KL; e.rot = 7'd60;  end
        5'd9:  begin base = 6'd16; e.src = SRC_KR; e.rot = 7'd60;  end
        5'd10: begin base = 6'd18; e.src = SRC_KB; e.rot = 7'd60;  end
        5'd11: begin base = 6'd20; e.src = SRC_KL; e.rot = 7'd77;  end
        5'd12: begin base = 6'd32; e.src = SRC_KA; e.rot = 7'd77;  end
        5'd13: begin base = 6'd22; e.src = SRC_KR; e.rot = 7'd94;  end
        5'd14: begin base = 6'd24; e.src = SRC_KA; e.rot = 7'd94;  end
        5'd15: begin base = 6'd26; e.src = SRC_KL; e.rot = 7'd111; end
        5'd16: begin base = 6'd2;  e.src = SRC_KB; e.rot = 7'd111; end
        default: begin base = 6'd0; end
      endcase
    end
    e.idx = base + {5'b00000, s[0]};
    e.hi  = ~s[0];
    return e;
  endfunction

endpackage

// File: rtl/cam_if.sv
// ----------------------------------------------------------------------------
// Camellia stream interfaces
// Valid/ready channels for input blocks and result blocks.
// ----------------------------------------------------------------------------
interface cam_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [63:0] in_high;
  logic [63:0] in_low;

  modport source (output valid, output mode, output in_high, output in_low, input ready);
  modport sink   (input valid, input mode, input in_high, input in_low, output ready);
endinterface

interface cam_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_high;
  logic [63:0] out_low;

  modport source (output valid, output out_high, output out_low, input ready);
  modport sink   (input valid, input out_high, input out_low, output ready);
endinterface

// File: rtl/cam_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module cam_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 34
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/cam_f.sv
// ----------------------------------------------------------------------------
// Camellia F function
// Key addition, S-box layer and P permutation on one 64-bit half.
// ----------------------------------------------------------------------------
module cam_f (
  input  logic [63:0] x_i,
  input  logic [63:0] k_i,
  output logic [63:0] y_o
);

  localparam logic [7:0] SBOX [256] = '{
    8'd112,8'd130,8'd44,8'd236,8'd179,8'd39,8'd192,8'd229,
    8'd228,8'd133,8'd87,8'd53,8'd234,8'd12,8'd174,8'd65,
    8'd35,8'd239,8'd107,8'd147,8'd69,8'd25,8'd165,8'd33,
    8'd237,8'd14,8'd79,8'd78,8'd29,8'd101,8'd146,8'd189,
    8'd134,8'd184,8'd175,8'd143,8'd124,8'd235,8'd31,8'd206,
    8'd62,8'd48,8'd220,8'd95,8'd94,8'd197,8'd11,8'd26,
    8'd166,8'd225,8'd57,8'd202,8'd213,8'd71,8'd93,8'd61,
    8'd217,8'd1,8'd90,8'd214,8'd81,8'd86,8'd108,8'd77,
    8'd139,8'd13,8'd154,8'd102,8'd251,8'd204,8'd176,8'd45,
    8'd116,8'd18,8'd43,8'd32,8'd240,8'd177,8'd132,8'd153,
    8'd223,8'd76,8'd203,8'd194,8'd52,8'd126,8'd118,8'd5,
    8'd109,8'd183,8'd169,8'd49,8'd209,8'd23,8'd4,8'd215,
    8'd20,8'd88,8'd58,8'd97,8'd222,8'd27,8'd17,8'd28,
    8'd50,8'd15,8'd156,8'd22,8'd83,8'd24,8'd242,8'd34,
    8'd254,8'd68,8'd207,8'd178,8'd195,8'd181,8'd122,8'd145,
    8'd36,8'd8,8'd232,8'd168,8'd96,8'd252,8'd105,8'd80,
    8'd170,8'd208,8'd160,8'd125,8'd161,8'd137,8'd98,8'd151,
    8'd84,8'd91,8'd30,8'd149,8'd224,8'd255,8'd100,8'd210,
    8'd16,8'd196,8'd0,8'd72,8'd163,8'd247,8'd117,8'd219,
    8'd138,8'd3,8'd230,8'd218,8'd9,8'd63,8'd221,8'd148,
    8'd135,8'd92,8'd131,8'd2,8'd205,8'd74,8'd144,8'd51,
    8'd115,8'd103,8'd246,8'd243,8'd157,8'd127,8'd191,8'd226,
    8'd82,8'd155,8'd216,8'd38,8'd200,8'd55,8'd198,8'd59,
    8'd129,8'd150,8'd111,8'd75,8'd19,8'd190,8'd99,8'd46,
    8'd233,8'd121,8'd167,8'd140,8'd159,8'd110,8'd188,8'd142,
    8'd41,8'd245,8'd249,8'd182,8'd47,8'd253,8'd180,8'd89,
    8'd120,8'd152,8'd6,8'd106,8'd231,8'd70,8'd113,8'd186,
    8'd212,8'd37,8'd171,8'd66,8'd136,8'd162,8'd141,8'd250,
    8'd114,8'd7,8'd185,8'd85,8'd248,8'd238,8'd172,8'd10,
    8'd54,8'd73,8'd42,8'd104,8'd60,8'd56,8'd241,8'd164,
    8'd64,8'd40,8'd211,8'd123,8'd187,8'd201,8'd67,8'd193,
    8'd21,8'd227,8'd173,8'd244,8'd119,8'd199,8'd128,8'd158
  };

  function automatic logic [7:0] rl1(logic [7:0] v);
    return {v[6:0], v[7]};
  endfunction

  function automatic logic [7:0] rr1(logic [7:0] v);
    return {v[0], v[7:1]};
  endfunction

  logic [63:0] v;
  logic [7:0]  t0, t1, t2, t3, t4, t5, t6, t7;

  always_comb begin
    v  = x_i ^ k_i;
    t0 = SBOX[v[63:56]];
    t1 = rl1(SBOX[v[55:48]]);
    t2 = rr1(SBOX[v[47:40]]);
    t3 = SBOX[rl1(v[39:32])];
    t4 = rl1(SBOX[v[31:24]]);
    t5 = rr1(SBOX[v[23:16]]);
    t6 = SBOX[rl1(v[15:8])];
    t7 = SBOX[v[7:0]];
    y_o = {t0 ^ t2 ^ t3 ^ t5 ^ t6 ^ t7,
           t0 ^ t1 ^ t3 ^ t4 ^ t6 ^ t7,
           t0 ^ t1 ^ t2 ^ t4 ^ t5 ^ t7,
           t1 ^ t2 ^ t3 ^ t4 ^ t5 ^ t6,
           t0 ^ t1 ^ t5 ^ t6 ^ t7,
           t1 ^ t2 ^ t4 ^ t6 ^ t7,
           t2 ^ t3 ^ t4 ^ t5 ^ t7,
           t0 ^ t3 ^ t4 ^ t5 ^ t6};
  end

endmodule

// File: rtl/camellia_block_cipher.sv
// ----------------------------------------------------------------------------
// Camellia block cipher
// Iterative Camellia-128/192/256 with a subkey RAM and one shared F unit.
// ----------------------------------------------------------------------------
// One 128-bit block is processed at a time: once the block is accepted,
// one operation (whitening, F round or FL half-layer) runs per cycle; F
// rounds use the single shared F unit, and subkeys come from one read port
// of the subkey RAM. A block takes 26 operations for 128-bit keys and 34
// otherwise. The first block after reset or after any key register write
// first derives KA (and KB) through the shared F unit and then fills the
// subkey RAM one entry per cycle. The result register lets a finished
// block wait while the next transaction is accepted.
module camellia_block_cipher #(
  parameter int SUBKEY_COUNT = 34
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  cam_in_if.sink      in_chan,
  cam_out_if.source   out_chan
);

  localparam int AW = $clog2(SUBKEY_COUNT);
  localparam logic [cam_pkg::KIDX_W-1:0] DEPTH_L = cam_pkg::KIDX_W'(SUBKEY_COUNT);

  cam_pkg::state_t state_r, state_nxt;
  logic [63:0]  key0_r, key0_nxt, key1_r, key1_nxt, key2_r, key2_nxt, key3_r, key3_nxt;
  logic [1:0]   klen_r, klen_nxt;
  logic         sched_ok_r, sched_ok_nxt;
  logic [127:0] ka_r, ka_nxt, kb_r, kb_nxt, d_r, d_nxt;
  logic         dec_r, dec_nxt;
  logic [5:0]   step_r, step_nxt;
  logic         exec_v_r, exec_v_nxt;
  logic [5:0]   exec_p_r, exec_p_nxt;
  logic         rd_oob_r, rd_oob_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [127:0] out_data_r, out_data_nxt;

  logic         big;
  logic [127:0] kl, kr, pair, src_v;
  logic [255:0] rot_w;
  logic [5:0]   nops, nwr;
  logic [63:0]  fx, fk, fy, rkey, ram_rdata, wword;
  logic [5:0]   raddr_full;
  logic         ram_we;
  cam_pkg::op_t   iss_op, ex_op;
  cam_pkg::sched_t sent;

  assign big  = (klen_r != cam_pkg::KLEN_128);
  assign kl   = {key0_r, key1_r};
  assign nops = big ? 6'd34 : 6'd26;
  assign nwr  = big ? 6'd34 : 6'd26;
  assign rkey = rd_oob_r ? 64'd0 : ram_rdata;

  always_comb begin
    case (klen_r)
      cam_pkg::KLEN_128: kr = 128'd0;
      cam_pkg::KLEN_192: kr = {key2_r, ~key2_r};
      default:           kr = {key2_r, key3_r};
    endcase
  end

  assign iss_op = cam_pkg::cam_op(big, dec_r, step_r);
  assign ex_op  = cam_pkg::cam_op(big, dec_r, exec_p_r);
  assign sent   = cam_pkg::sched_entry(big, step_r);

  always_comb begin
    case (sent.src)
      cam_pkg::SRC_KL: src_v = kl;
      cam_pkg::SRC_KR: src_v = kr;
      cam_pkg::SRC_KA: src_v = ka_r;
      default:         src_v = kb_r;
    endcase
    rot_w = {src_v, src_v} << sent.rot;
    wword = sent.hi ? rot_w[255:192] : rot_w[191:128];
  end

  always_comb begin
    pair = (step_r < 6'd4) ? ka_r : kb_r;
    if (state_r == cam_pkg::ST_KEYF) begin
      fx = step_r[0] ? pair[63:0] : pair[127:64];
      fk = cam_pkg::SIGMA[step_r[2:0]];
    end else begin
      fx = (ex_op.kind == cam_pkg::OP_F_ODD) ? d_r[63:0] : d_r[127:64];
      fk = rkey;
    end
  end

  cam_f u_f (
    .x_i (fx),
    .k_i (fk),
    .y_o (fy)
  );

  assign ram_we     = (state_r == cam_pkg::ST_KEYW) && (sent.idx < DEPTH_L);
  assign raddr_full = iss_op.addr;

  cam_ram #(
    .WIDTH (64),
    .DEPTH (SUBKEY_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sent.idx[AW-1:0]),
    .wdata (wword),
    .raddr (raddr_full[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    key0_nxt      = key0_r;
    key1_nxt      = key1_r;
    key2_nxt      = key2_r;
    key3_nxt      = key3_r;
    klen_nxt      = klen_r;
    sched_ok_nxt  = sched_ok_r;
    ka_nxt        = ka_r;
    kb_nxt        = kb_r;
    d_nxt         = d_r;
    dec_nxt       = dec_r;
    step_nxt      = step_r;
    exec_v_nxt    = 1'b0;
    exec_p_nxt    = exec_p_r;
    rd_oob_nxt    = raddr_full >= DEPTH_L;
    out_valid_nxt = out_valid_r & ~out_chan.ready;
    out_data_nxt  = out_data_r;

    case (state_r)
      cam_pkg::ST_IDLE: begin
        if (in_chan.valid) begin
          d_nxt    = {in_chan.in_high, in_chan.in_low};
          dec_nxt  = in_chan.mode;
          step_nxt = 6'd0;
          if (sched_ok_r) begin
            state_nxt = cam_pkg::ST_RUN;
          end else begin
            ka_nxt    = kl ^ kr;
            state_nxt = cam_pkg::ST_KEYF;
          end
        end
      end
      cam_pkg::ST_KEYF: begin
        step_nxt = step_r + 6'd1;
        case (step_r)
          6'd0, 6'd2: ka_nxt[63:0] = ka_r[63:0] ^ fy;
          6'd1: ka_nxt = {ka_r[127:64] ^ fy ^ kl[127:64], ka_r[63:0] ^ kl[63:0]};
          6'd3: begin
            ka_nxt[127:64] = ka_r[127:64] ^ fy;
            kb_nxt = {ka_r[127:64] ^ fy ^ kr[127:64], ka_r[63:0] ^ kr[63:0]};
            if (!big) begin
              step_nxt  = 6'd0;
              state_nxt = cam_pkg::ST_KEYW;
            end
          end
          6'd4: kb_nxt[63:0] = kb_r[63:0] ^ fy;
          default: begin
            kb_nxt[127:64] = kb_r[127:64] ^ fy;
            step_nxt       = 6'd0;
            state_nxt      = cam_pkg::ST_KEYW;
          end
        endcase
      end
      cam_pkg::ST_KEYW: begin
        step_nxt = step_r + 6'd1;
        if (step_r == nwr - 6'd1) begin
          step_nxt     = 6'd0;
          sched_ok_nxt = 1'b1;
          state_nxt    = cam_pkg::ST_RUN;
        end
      end
      cam_pkg::ST_RUN: begin
        if (step_r < nops) begin
          exec_v_nxt = 1'b1;
          exec_p_nxt = step_r;
          step_nxt   = step_r + 6'd1;
        end
        if (exec_v_r) begin
          case (ex_op.kind)
            cam_pkg::OP_XOR_HI: d_nxt[127:64] = d_r[127:64] ^ rkey;
            cam_pkg::OP_XOR_LO: d_nxt[63:0]   = d_r[63:0] ^ rkey;
            cam_pkg::OP_F_EVEN: d_nxt[63:0]   = d_r[63:0] ^ fy;
            cam_pkg::OP_F_ODD:  d_nxt[127:64] = d_r[127:64] ^ fy;
            cam_pkg::OP_FL:     d_nxt[127:64] = cam_pkg::fl(d_r[127:64], rkey);
            default:            d_nxt[63:0]   = cam_pkg::flinv(d_r[63:0], rkey);
          endcase
          if (exec_p_r == nops - 6'd1) begin
            state_nxt = cam_pkg::ST_FIN;
          end
        end
      end
      cam_pkg::ST_FIN: begin
        if (!out_valid_r || out_chan.ready) begin
          out_data_nxt  = {d_r[63:0], d_r[127:64]};
          out_valid_nxt = 1'b1;
          state_nxt     = cam_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cam_pkg::ST_IDLE;
    endcase

    if (cfg_we) begin
      case (cfg_index)
        cam_pkg::CFG_KEY0: begin key0_nxt = cfg_wdata;      sched_ok_nxt = 1'b0; end
        cam_pkg::CFG_KEY1: begin key1_nxt = cfg_wdata;      sched_ok_nxt = 1'b0; end
        cam_pkg::CFG_KEY2: begin key2_nxt = cfg_wdata;      sched_ok_nxt = 1'b0; end
        cam_pkg::CFG_KEY3: begin key3_nxt = cfg_wdata;      sched_ok_nxt = 1'b0; end
        cam_pkg::CFG_KLEN: begin klen_nxt = cfg_wdata[1:0]; sched_ok_nxt = 1'b0; end
        default: begin end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cam_pkg::ST_IDLE;
      key0_r      <= 64'd0;
      key1_r      <= 64'd0;
      key2_r      <= 64'd0;
      key3_r      <= 64'd0;
      klen_r      <= cam_pkg::KLEN_128;
      sched_ok_r  <= 1'b0;
      step_r      <= 6'd0;
      exec_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      key0_r      <= key0_nxt;
      key1_r      <= key1_nxt;
      key2_r      <= key2_nxt;
      key3_r      <= key3_nxt;
      klen_r      <= klen_nxt;
      sched_ok_r  <= sched_ok_nxt;
      step_r      <= step_nxt;
      exec_v_r    <= exec_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ka_r       <= ka_nxt;
    kb_r       <= kb_nxt;
    d_r        <= d_nxt;
    dec_r      <= dec_nxt;
    exec_p_r   <= exec_p_nxt;
    rd_oob_r   <= rd_oob_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_chan.ready     = (state_r == cam_pkg::ST_IDLE);
  assign out_chan.valid    = out_valid_r;
  assign out_chan.out_high = out_data_r[127:64];
  assign out_chan.out_low  = out_data_r[63:0];

  a_ram_write_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == cam_pkg::ST_KEYW))
    else $error("Subkey RAM written outside the fill phase.");

  a_run_needs_schedule: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cam_pkg::ST_RUN) |-> sched_ok_r)
    else $error("Block processing started without a complete key schedule.");

  a_exec_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    exec_v_r |-> (exec_p_r < nops))
    else $error("Operation index beyond the end of the block.");

  a_fin_follows_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cam_pkg::ST_FIN) |-> ($past(state_r) == cam_pkg::ST_RUN) ||
      ($past(state_r) == cam_pkg::ST_FIN))
    else $error("Result stage entered without running the rounds.");

endmodule
